[rtl/core/sfpr_pkg.sv]
// Shared types and constants for the sync-framed packet router.
// Holds the command word passed from the parser to the result sequencer.
// No dependencies.
`timescale 1ns / 1ps

package sfpr_pkg;

	localparam logic [7:0] SYNC_FIRST   = 8'h11;
	localparam logic [7:0] SYNC_SECOND  = 8'hAA;
	localparam logic [7:0] CONSOLE_EP   = 8'hFF;
	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

	localparam logic [1:0] ROUTE_LOCAL   = 2'd0;
	localparam logic [1:0] ROUTE_CONSOLE = 2'd1;
	localparam logic [1:0] ROUTE_FORWARD = 2'd2;
	localparam logic [1:0] ROUTE_SILENT  = 2'd3;

	localparam logic CFG_DEVICE_ID = 1'b0;
	localparam logic CFG_IS_ROUTER = 1'b1;

	// Command kinds: how many result beats a command expands into and how.
	localparam logic [2:0] KIND_DATA    = 3'd0; // one data beat
	localparam logic [2:0] KIND_EMPTY   = 3'd1; // empty marker for a local packet
	localparam logic [2:0] KIND_NL      = 3'd2; // newline only
	localparam logic [2:0] KIND_DATA_NL = 3'd3; // data beat, then newline
	localparam logic [2:0] KIND_HDR     = 3'd4; // sync, sync, endpoint, length

	typedef struct packed {
		logic [1:0] route;
		logic [2:0] kind;
		logic [7:0] data;
		logic [7:0] ep;
		logic       last;
	} cmd_t;

endpackage

[rtl/core/sfpr_front.sv]
// Frame parser: hunts for sync, reads endpoint and length, picks the route
// and issues one command per byte that produces results. Uses sfpr_pkg.
`timescale 1ns / 1ps

module sfpr_front
	import sfpr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	output logic       cmd_valid,
	input  logic       cmd_ready,
	output cmd_t       cmd
);

	localparam logic [2:0] PH_HUNT = 3'd0;
	localparam logic [2:0] PH_SEEN = 3'd1;
	localparam logic [2:0] PH_EP   = 3'd2;
	localparam logic [2:0] PH_LEN  = 3'd3;
	localparam logic [2:0] PH_DATA = 3'd4;

	logic [7:0] device_id_q;
	logic       is_router_q;
	logic [2:0] phase_q;
	logic [7:0] ep_q;
	logic [7:0] left_q;
	logic [1:0] route_q;

	logic       accept;
	logic       emit;
	logic [2:0] phase_d;
	logic [1:0] len_route;
	logic       final_byte;

	assign cfg_ready = 1'b1;
	// The queue must have room before a byte is taken.
	assign in_ready  = cmd_ready;
	assign accept    = in_valid && in_ready;
	assign cmd_valid = accept && emit;

	always_comb begin
		if (ep_q == device_id_q) begin
			len_route = ROUTE_LOCAL;
		end else if (is_router_q && ep_q == CONSOLE_EP) begin
			len_route = ROUTE_CONSOLE;
		end else if (is_router_q) begin
			len_route = ROUTE_FORWARD;
		end else begin
			len_route = ROUTE_SILENT;
		end
	end

	assign final_byte = (left_q <= 8'd1);

	always_comb begin
		emit      = 1'b0;
		phase_d   = phase_q;
		cmd.route = route_q;
		cmd.kind  = KIND_DATA;
		cmd.data  = rx_byte;
		cmd.ep    = ep_q;
		cmd.last  = 1'b0;
		case (phase_q)
			PH_SEEN: begin
				if (rx_byte == SYNC_SECOND) begin
					phase_d = PH_EP;
				end else if (rx_byte == SYNC_FIRST) begin
					phase_d = PH_SEEN;
				end else begin
					phase_d = PH_HUNT;
				end
			end
			PH_EP: begin
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				cmd.route = len_route;
				cmd.last  = (rx_byte == 8'd0);
				if (len_route == ROUTE_FORWARD) begin
					emit     = 1'b1;
					cmd.kind = KIND_HDR;
				end else if (rx_byte == 8'd0 && len_route == ROUTE_LOCAL) begin
					emit     = 1'b1;
					cmd.kind = KIND_EMPTY;
					cmd.data = 8'd0;
				end else if (rx_byte == 8'd0 && len_route == ROUTE_CONSOLE) begin
					emit     = 1'b1;
					cmd.kind = KIND_NL;
					cmd.data = NEWLINE_BYTE;
				end
				phase_d = (rx_byte == 8'd0) ? PH_HUNT : PH_DATA;
			end
			PH_DATA: begin
				emit = (route_q != ROUTE_SILENT);
				if (route_q == ROUTE_CONSOLE) begin
					cmd.kind = final_byte ? KIND_DATA_NL : KIND_DATA;
				end else begin
					cmd.last = final_byte;
				end
				if (final_byte) begin
					phase_d = PH_HUNT;
				end
			end
			default: begin
				phase_d = (rx_byte == SYNC_FIRST) ? PH_SEEN : PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_id_q <= 8'd0;
			is_router_q <= 1'b0;
			phase_q     <= PH_HUNT;
			ep_q        <= 8'd0;
			left_q      <= 8'd0;
			route_q     <= ROUTE_LOCAL;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DEVICE_ID: device_id_q <= cfg_data;
					CFG_IS_ROUTER: is_router_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (accept) begin
				phase_q <= phase_d;
				if (phase_q == PH_EP) begin
					ep_q <= rx_byte;
				end
				if (phase_q == PH_LEN) begin
					left_q  <= rx_byte;
					route_q <= len_route;
				end
				if (phase_q == PH_DATA) begin
					left_q <= final_byte ? 8'd0 : left_q - 8'd1;
				end
			end
		end
	end

endmodule

[rtl/core/sfpr_fifo.sv]
// Short command queue between the parser and the result sequencer.
// Register-based, first-word fall-through. Uses sfpr_pkg for cmd_t.
`timescale 1ns / 1ps

module sfpr_fifo
	import sfpr_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  cmd_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output cmd_t rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = entry_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/sfpr_back.sv]
// Result sequencer: expands each queued command into one to four result
// beats and holds them in an output register. Uses sfpr_pkg.
`timescale 1ns / 1ps

module sfpr_back
	import sfpr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  cmd_t       cmd,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] route,
	output logic [7:0] out_byte,
	output logic [7:0] endpoint,
	output logic       last,
	output logic       empty_res
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [1:0] route_q;
	logic [7:0] byte_q;
	logic [7:0] ep_q;
	logic       last_q;
	logic       empty_q;

	logic       load;
	logic       final_beat;
	logic [7:0] res_byte;
	logic       res_last;
	logic       res_empty;

	assign load      = cmd_valid && (!out_valid_q || out_ready);
	assign cmd_ready = load && final_beat;

	always_comb begin
		res_byte   = cmd.data;
		res_last   = cmd.last;
		res_empty  = 1'b0;
		final_beat = 1'b1;
		case (cmd.kind)
			KIND_DATA: ;
			KIND_EMPTY: begin
				res_byte  = 8'd0;
				res_last  = 1'b1;
				res_empty = 1'b1;
			end
			KIND_NL: begin
				res_byte = NEWLINE_BYTE;
				res_last = 1'b1;
			end
			KIND_DATA_NL: begin
				final_beat = (idx_q == 2'd1);
				res_byte   = final_beat ? NEWLINE_BYTE : cmd.data;
				res_last   = final_beat;
			end
			KIND_HDR: begin
				final_beat = (idx_q == 2'd3);
				res_last   = final_beat && cmd.last;
				case (idx_q)
					2'd0:    res_byte = SYNC_FIRST;
					2'd1:    res_byte = SYNC_SECOND;
					2'd2:    res_byte = cmd.ep;
					default: res_byte = cmd.data;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= final_beat ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			route_q <= cmd.route;
			byte_q  <= res_byte;
			ep_q    <= cmd.ep;
			last_q  <= res_last;
			empty_q <= res_empty;
		end
	end

	assign out_valid = out_valid_q;
	assign route     = route_q;
	assign out_byte  = byte_q;
	assign endpoint  = ep_q;
	assign last      = last_q;
	assign empty_res = empty_q;

endmodule

[rtl/core/sync_framed_packet_router.sv]
// Top level of the sync-framed packet router: parser, command queue and
// result sequencer. Depends on sfpr_pkg, sfpr_front, sfpr_fifo, sfpr_back.
`timescale 1ns / 1ps

// The router takes one received link byte per beat on the input channel and
// can accept a byte in every clock cycle while the command queue has room.
// It hunts for the sync pair 0x11 0xAA (a repeated 0x11 keeps the hunt armed),
// then reads an endpoint byte, a length byte and that many payload bytes. The
// route is fixed when the length byte arrives: an endpoint equal to device_id
// is delivered locally (route 0); with is_router set, endpoint 255 goes to the
// console (route 1) with a newline beat after the payload, and any other
// endpoint is forwarded (route 2) with the sync pair, endpoint and length
// emitted as header beats before the data. Everything else is dropped. A
// zero-length local packet gives a single beat with empty_res set. The output
// side delivers one result beat per cycle while out_ready is high, from a
// registered output stage; a forwarded length byte makes four beats, and the
// command queue (QUEUE_DEPTH entries) absorbs these bursts so the input keeps
// flowing while it has room. Each command passes through the queue and its
// result beat is then registered in the output stage. Configuration (index 0
// device_id, index 1 is_router) is always ready and should be written only
// while the block is idle.
module sync_framed_packet_router
	import sfpr_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	// Received byte channel.
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	// Configuration write channel.
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	// Result channel.
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] route,
	output logic [7:0] out_byte,
	output logic [7:0] endpoint,
	output logic       last,
	output logic       empty_res
);

	// Commands from the parser into the queue.
	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;

	// Commands from the queue into the sequencer.
	logic head_valid;
	logic head_ready;
	cmd_t head_cmd;

	// The parser classifies each byte and issues at most one command for it.
	sfpr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (push_valid),
		.cmd_ready (push_ready),
		.cmd       (push_cmd)
	);

	// The queue lets the parser run ahead while the output is busy with a
	// multi-beat command or stalled by the consumer.
	sfpr_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_data  (push_cmd),
		.rd_valid (head_valid),
		.rd_ready (head_ready),
		.rd_data  (head_cmd)
	);

	// The sequencer walks each command beat by beat into the output register.
	sfpr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (head_valid),
		.cmd_ready (head_ready),
		.cmd       (head_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.route     (route),
		.out_byte  (out_byte),
		.endpoint  (endpoint),
		.last      (last),
		.empty_res (empty_res)
	);

endmodule

[bench/sfpr_route_checker.sv]
// Result checker for the sync-framed packet router: watches all three channels,
// predicts the result beats of every accepted byte and compares them in order.
// Depends on sfpr_pkg.
`timescale 1ns / 1ps

module sfpr_route_checker
	import sfpr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [1:0] route,
	input  logic [7:0] out_byte,
	input  logic [7:0] endpoint,
	input  logic       last,
	input  logic       empty_res,
	output int         fail_count,
	output int         beats_pending
);

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_SEEN,
		PH_EP,
		PH_LEN,
		PH_DATA
	} parse_phase_t;

	typedef struct packed {
		logic [1:0] route;
		logic [7:0] data;
		logic [7:0] ep;
		logic       last;
		logic       empty;
	} route_beat_t;

	route_beat_t  beats_due[$];
	parse_phase_t phase;
	logic [7:0]   device_id;
	logic         is_router;
	logic [7:0]   pkt_ep;
	logic [7:0]   bytes_left;
	logic [1:0]   pkt_route;
	int           errors;

	function automatic void due_beat(input logic [1:0] rt, input logic [7:0] data,
			input logic lst, input logic empty);
		beats_due.push_back('{rt, data, pkt_ep, lst, empty});
	endfunction

	// Advances the parser by one received byte and queues the beats it causes.
	task automatic parse_rx_byte(input logic [7:0] b);
		logic final_byte;
		case (phase)
			PH_SEEN: begin
				if (b == SYNC_SECOND)
					phase = PH_EP;
				else if (b == SYNC_FIRST)
					phase = PH_SEEN;
				else
					phase = PH_HUNT;
			end
			PH_EP: begin
				pkt_ep = b;
				phase = PH_LEN;
			end
			PH_LEN: begin
				bytes_left = b;
				if (pkt_ep == device_id)
					pkt_route = ROUTE_LOCAL;
				else if (is_router && pkt_ep == CONSOLE_EP)
					pkt_route = ROUTE_CONSOLE;
				else if (is_router)
					pkt_route = ROUTE_FORWARD;
				else
					pkt_route = ROUTE_SILENT;
				if (pkt_route == ROUTE_FORWARD) begin
					due_beat(ROUTE_FORWARD, SYNC_FIRST, 1'b0, 1'b0);
					due_beat(ROUTE_FORWARD, SYNC_SECOND, 1'b0, 1'b0);
					due_beat(ROUTE_FORWARD, pkt_ep, 1'b0, 1'b0);
					due_beat(ROUTE_FORWARD, b, b == 8'd0, 1'b0);
				end else if (b == 8'd0 && pkt_route == ROUTE_LOCAL) begin
					due_beat(ROUTE_LOCAL, 8'd0, 1'b1, 1'b1);
				end else if (b == 8'd0 && pkt_route == ROUTE_CONSOLE) begin
					due_beat(ROUTE_CONSOLE, NEWLINE_BYTE, 1'b1, 1'b0);
				end
				phase = (b == 8'd0) ? PH_HUNT : PH_DATA;
			end
			PH_DATA: begin
				final_byte = (bytes_left <= 8'd1);
				if (pkt_route == ROUTE_CONSOLE) begin
					due_beat(ROUTE_CONSOLE, b, 1'b0, 1'b0);
					if (final_byte)
						due_beat(ROUTE_CONSOLE, NEWLINE_BYTE, 1'b1, 1'b0);
				end else if (pkt_route != ROUTE_SILENT) begin
					due_beat(pkt_route, b, final_byte, 1'b0);
				end
				bytes_left = final_byte ? 8'd0 : bytes_left - 8'd1;
				if (final_byte)
					phase = PH_HUNT;
			end
			default: begin
				phase = (b == SYNC_FIRST) ? PH_SEEN : PH_HUNT;
			end
		endcase
	endtask

	task automatic compare_field(input string name, input int expected, input int actual);
		if (expected != actual) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, name, expected, actual);
			errors++;
		end
	endtask

	task automatic check_route_beat();
		route_beat_t want;
		if (beats_due.size() == 0) begin
			$display({"%0t: unexpected beat, expected none, actual route %0d byte 0x%0h",
				" ep 0x%0h last %0b empty %0b"},
				$time, route, out_byte, endpoint, last, empty_res);
			errors++;
		end else begin
			want = beats_due.pop_front();
			compare_field("route", int'(want.route), int'(route));
			compare_field("out_byte", int'(want.data), int'(out_byte));
			compare_field("endpoint", int'(want.ep), int'(endpoint));
			compare_field("last", int'(want.last), int'(last));
			compare_field("empty_res", int'(want.empty), int'(empty_res));
		end
	endtask

	// Counts are published with nonblocking updates so the stimulus side always
	// sees values settled at the previous edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = PH_HUNT;
			device_id = 8'd0;
			is_router = 1'b0;
			pkt_ep = 8'd0;
			bytes_left = 8'd0;
			pkt_route = ROUTE_LOCAL;
			errors = 0;
			beats_due.delete();
			fail_count <= 0;
			beats_pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_DEVICE_ID)
					device_id = cfg_data;
				else
					is_router = cfg_data[0];
			end
			if (in_valid && in_ready)
				parse_rx_byte(rx_byte);
			if (out_valid && out_ready)
				check_route_beat();
			fail_count <= errors;
			beats_pending <= beats_due.size();
		end
	end

endmodule

[bench/tb_sync_framed_packet_router.sv]
// Testbench top for the sync-framed packet router: clock, reset, stimulus and
// the final verdict. Depends on sfpr_pkg, sync_framed_packet_router and
// sfpr_route_checker.
`timescale 1ns / 1ps

module tb_sync_framed_packet_router;
	import sfpr_pkg::*;

	// Cycles allowed after the last expected beat for bytes that make no beat
	// to leave the parser and command queue.
	localparam int DRAIN_CYCLES = 12;
	localparam int ITEM_TARGET  = 480;
	localparam int CYCLE_LIMIT  = 500000;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte   = 8'd0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_index = CFG_DEVICE_ID;
	logic [7:0] cfg_data  = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] route;
	logic [7:0] out_byte;
	logic [7:0] endpoint;
	logic       last;
	logic       empty_res;
	int         fail_count;
	int         beats_pending;

	int cycle_count = 0;
	int burst_left  = 0;
	int items_sent  = 0;
	int stall_mode  = 0;
	int mode_cycles = 0;
	logic [7:0] cur_device_id = 8'd0;

	sync_framed_packet_router dut (.*);

	sfpr_route_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a correct run finishes far below this.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// The result side cycles through stall styles: always ready, coin flips,
	// mostly stalled, and a periodic rhythm of equal ready and stalled runs.
	always @(posedge clk) begin
		if (mode_cycles == 0) begin
			stall_mode <= $urandom_range(0, 3);
			mode_cycles <= $urandom_range(20, 80);
		end else begin
			mode_cycles <= mode_cycles - 1;
		end
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= ((cycle_count % 16) < 8);
		endcase
	end

	// Sends one byte beat. The sender works in bursts; when a burst runs out,
	// valid drops for a random gap before the next burst begins.
	task automatic send_byte(input logic [7:0] b);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		burst_left--;
	endtask

	// A well-formed frame: sync pair, endpoint, length and random payload.
	task automatic send_packet(input logic [7:0] ep, input logic [7:0] len);
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		send_byte(ep);
		send_byte(len);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(0, 255)));
		items_sent += 4 + len;
	endtask

	// Waits until every predicted beat has arrived and the block has had time
	// to finish bytes that give no beat.
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (beats_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes both registers back to back while the block is idle.
	task automatic set_config(input logic [7:0] dev_id, input logic router);
		settle();
		cur_device_id = dev_id;
		cfg_valid <= 1'b1;
		cfg_index <= CFG_DEVICE_ID;
		cfg_data <= dev_id;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= CFG_IS_ROUTER;
		cfg_data <= {7'd0, router};
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int r;
		int packets_left;
		logic [7:0] ep;
		logic [7:0] len;
		logic [7:0] junk;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Router mode with device id zero: a noise byte, a
		// repeated first sync byte, then zero-length local, console and
		// forwarded frames and one-byte console and forwarded frames.
		set_config(8'h00, 1'b1);
		send_byte(8'h00);
		send_byte(SYNC_FIRST);
		send_packet(8'h00, 8'd0);
		send_packet(CONSOLE_EP, 8'd0);
		send_packet(8'h7E, 8'd0);
		send_packet(CONSOLE_EP, 8'd1);
		send_packet(8'h80, 8'd1);

		// Device id 255 wins over the console endpoint.
		set_config(8'hFF, 1'b1);
		send_packet(CONSOLE_EP, 8'd2);

		// A register write between the endpoint and the length byte applies to
		// the frame in progress, since the route is taken at the length byte.
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		send_byte(8'h05);
		set_config(8'h05, 1'b0);
		send_byte(8'd1);
		send_byte(8'hFF);

		// Foreign endpoint with routing off is swallowed.
		send_packet(8'h33, 8'd1);

		// A write after the length byte leaves the frame on its old route.
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		send_byte(8'h05);
		send_byte(8'd2);
		send_byte(8'hC3);
		set_config(8'h06, 1'b1);
		send_byte(8'h3C);

		// Random part: mostly well-formed frames with random content, some
		// line noise and some sync pairs that break off. Noise can also cut a
		// frame short, so frames get misparsed now and then on purpose.
		packets_left = 0;
		while (items_sent < ITEM_TARGET) begin
			if (packets_left == 0) begin
				case ($urandom_range(0, 3))
					0: set_config(8'h00, 1'($urandom_range(0, 1)));
					1: set_config(8'hFF, 1'($urandom_range(0, 1)));
					default: set_config(8'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)));
				endcase
				packets_left = $urandom_range(4, 12);
			end
			r = $urandom_range(0, 99);
			if (r < 12) begin
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
			end else if (r < 20) begin
				if ($urandom_range(0, 1))
					send_byte(SYNC_FIRST);
				send_byte(SYNC_FIRST);
				junk = 8'($urandom_range(0, 255));
				send_byte(junk == SYNC_SECOND ? 8'h00 : junk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 40)
					ep = cur_device_id;
				else if (r < 65)
					ep = CONSOLE_EP;
				else
					ep = 8'($urandom_range(0, 255));
				// Mostly short frames; a rare long one reaches the upper lengths.
				r = $urandom_range(0, 99);
				if (r < 75)
					len = 8'($urandom_range(0, 5));
				else if (r < 99)
					len = 8'($urandom_range(6, 24));
				else
					len = 8'($urandom_range(100, 255));
				send_packet(ep, len);
				packets_left--;
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (beats_pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
